/* rtl/hsl_pkg.sv */
package hsl_pkg;

   // Field widths of the request and response
   localparam int unsigned HUE_W  = 9;
   localparam int unsigned TURN_W = 6;
   localparam int unsigned RB_W   = 5;
   localparam int unsigned G_W    = 6;

   // Hue geometry
   localparam int unsigned HUE_LIMIT  = 360;
   localparam int unsigned SECTOR_DEG = 60;
   localparam int unsigned SECTORS    = 6;

   typedef enum logic [2:0] {
      SECT_RED_YEL = 3'd0,
      SECT_YEL_GRN = 3'd1,
      SECT_GRN_CYN = 3'd2,
      SECT_CYN_BLU = 3'd3,
      SECT_BLU_MAG = 3'd4,
      SECT_MAG_RED = 3'd5
   } sector_type;

   typedef struct packed {
      sector_type              sector;
      logic [TURN_W-1:0]       turn;     // degrees into the sector, mirrored on odd sectors
      logic                    hue_err;
   } hue_info_type;

   // Width of a clamped saturation or lightness: at most ONE, never above the field range
   function automatic int unsigned val_width(input int unsigned frac_bits);
      return (frac_bits + 1 < HUE_W) ? frac_bits + 1 : HUE_W;
   endfunction

endpackage

/* rtl/hsl_sector.sv */
module hsl_sector #(
   parameter  int unsigned FRAC_BITS = 8,
   localparam int unsigned VAL_W     = hsl_pkg::val_width(FRAC_BITS),
   localparam int unsigned SPAN_W    = FRAC_BITS + 1
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  logic [hsl_pkg::HUE_W-1:0] hue_deg,
   input  logic [hsl_pkg::HUE_W-1:0] saturation,
   input  logic [hsl_pkg::HUE_W-1:0] lightness,
   output logic                      out_valid,
   input  logic                      out_ready,
   output hsl_pkg::hue_info_type     info,
   output logic [SPAN_W-1:0]         span,
   output logic [VAL_W-1:0]          sat,
   output logic [VAL_W-1:0]          light
);
   import hsl_pkg::*;

   localparam int unsigned ONE  = 1 << FRAC_BITS;
   localparam int unsigned TW_W = FRAC_BITS + 2;

   logic [VAL_W-1:0]  sat_in, light_in, sat_ff, light_ff;
   logic [TW_W-1:0]   twol, dev;
   logic [SPAN_W-1:0] span_in, span_ff;
   logic [HUE_W-1:0]  base, rem;
   sector_type        sect;
   logic [TURN_W-1:0] turn;
   hue_info_type      info_in, info_ff;
   logic              valid_in, valid_ff;

   // clamp S and L to one, then 1 - |2L - 1|
   always_comb begin
      sat_in   = (32'(saturation) > ONE) ? VAL_W'(ONE) : VAL_W'(saturation);
      light_in = (32'(lightness) > ONE) ? VAL_W'(ONE) : VAL_W'(lightness);
      twol     = TW_W'(light_in) << 1;
      dev      = (twol >= TW_W'(ONE)) ? twol - TW_W'(ONE) : TW_W'(ONE) - twol;
      span_in  = SPAN_W'(TW_W'(ONE) - dev);
   end

   // sector by threshold compares, remainder against the sector base
   always_comb begin
      sect = SECT_RED_YEL;
      base = '0;
      for (int i = 1; i < SECTORS; i++) begin
         if (hue_deg >= HUE_W'(i * SECTOR_DEG)) begin
            sect = sector_type'(3'(i));
            base = HUE_W'(i * SECTOR_DEG);
         end
      end
      rem  = hue_deg - base;
      turn = sect[0] ? TURN_W'(SECTOR_DEG) - TURN_W'(rem) : TURN_W'(rem);
      info_in = '{sector: sect, turn: turn, hue_err: (hue_deg >= HUE_W'(HUE_LIMIT))};
   end

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         info_ff  <= info_in;
         span_ff  <= span_in;
         sat_ff   <= sat_in;
         light_ff <= light_in;
      end
   end

   assign out_valid = valid_ff;
   assign info      = info_ff;
   assign span      = span_ff;
   assign sat       = sat_ff;
   assign light     = light_ff;

`ifndef SYNTHESIS
   a_turn_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff && !info_ff.hue_err |-> info_ff.turn <= TURN_W'(SECTOR_DEG))
      else $error("sector offset beyond one sector");
`endif

endmodule

/* rtl/hsl_chroma.sv */
module hsl_chroma #(
   parameter  int unsigned FRAC_BITS = 8,
   localparam int unsigned VAL_W     = hsl_pkg::val_width(FRAC_BITS),
   localparam int unsigned SPAN_W    = FRAC_BITS + 1,
   localparam int unsigned U_W       = 2 * FRAC_BITS + 6
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  hsl_pkg::hue_info_type in_info,
   input  logic [SPAN_W-1:0]     span,
   input  logic [VAL_W-1:0]      sat,
   input  logic [VAL_W-1:0]      light,
   output logic                  out_valid,
   input  logic                  out_ready,
   output hsl_pkg::hue_info_type out_info,
   output logic [U_W-1:0]        comp_c,
   output logic [U_W-1:0]        comp_x,
   output logic [U_W-1:0]        comp_m
);
   import hsl_pkg::*;

   localparam int unsigned CN_W = 2 * FRAC_BITS + 1;

   // stage A: chroma in units of 1/ONE^2
   logic              va_in, va_ff, ready_a;
   hue_info_type      info_a_ff;
   logic [CN_W-1:0]   cn_in, cn_ff;
   logic [VAL_W-1:0]  light_a_ff;

   // stage B: components in units of 1/(60*ONE^2)
   logic              vb_in, vb_ff, ready_b;
   hue_info_type      info_b_ff;
   logic [U_W-1:0]    c_in, x_in, m_in, c_ff, x_ff, m_ff;

   assign ready_b  = !vb_ff || out_ready;
   assign ready_a  = !va_ff || ready_b;
   assign in_ready = ready_a;

   assign va_in = ready_a ? in_valid : va_ff;
   assign vb_in = ready_b ? va_ff : vb_ff;

   assign cn_in = CN_W'(span) * CN_W'(sat);

   always_comb begin
      c_in = U_W'(cn_ff) * U_W'(SECTOR_DEG);
      x_in = U_W'(cn_ff) * U_W'(info_a_ff.turn);
      m_in = ((U_W'(light_a_ff) * U_W'(SECTOR_DEG)) << FRAC_BITS)
             - U_W'(cn_ff) * U_W'(SECTOR_DEG / 2);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
      end else begin
         va_ff <= va_in;
         vb_ff <= vb_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && ready_a) begin
         info_a_ff  <= in_info;
         cn_ff      <= cn_in;
         light_a_ff <= light;
      end
      if (va_ff && ready_b) begin
         info_b_ff <= info_a_ff;
         c_ff      <= c_in;
         x_ff      <= x_in;
         m_ff      <= m_in;
      end
   end

   assign out_valid = vb_ff;
   assign out_info  = info_b_ff;
   assign comp_c    = c_ff;
   assign comp_x    = x_ff;
   assign comp_m    = m_ff;

endmodule

/* rtl/hsl_pack.sv */
module hsl_pack #(
   parameter  int unsigned FRAC_BITS = 8,
   localparam int unsigned U_W       = 2 * FRAC_BITS + 6
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  hsl_pkg::hue_info_type info,
   input  logic [U_W-1:0]        comp_c,
   input  logic [U_W-1:0]        comp_x,
   input  logic [U_W-1:0]        comp_m,
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic [15:0]           out_rgb,
   output logic                  out_err
);
   import hsl_pkg::*;

   localparam int unsigned LEVEL_W     = 10;
   localparam int unsigned RECIP_15    = 2185;   // 2^15 / 15, rounded up
   localparam int unsigned RECIP_W     = 12;
   localparam int unsigned RECIP_SHIFT = 15;
   localparam int unsigned PROD_W      = LEVEL_W + RECIP_W;
   localparam int unsigned QW          = PROD_W - RECIP_SHIFT;
   localparam int unsigned RB_MAX      = (1 << RB_W) - 1;
   localparam int unsigned G_MAX       = (1 << G_W) - 1;
   localparam int unsigned RB_LVL_MAX  = 8 * SECTOR_DEG;
   localparam int unsigned G_LVL_MAX   = 16 * SECTOR_DEG;

   // floor(n / 15) for n below 1024
   function automatic logic [QW-1:0] div15(input logic [LEVEL_W-1:0] n);
      logic [PROD_W-1:0] p;
      p = PROD_W'(n) * PROD_W'(RECIP_15);
      return QW'(p >> RECIP_SHIFT);
   endfunction

   logic [U_W-1:0]     rv, gv, bv, ur, ug, ub;
   logic [LEVEL_W-1:0] lr_in, lg_in, lb_in, lr_ff, lg_ff, lb_ff;
   logic               lvl_err_ff;
   logic               vl_in, vl_ff, ready_l;
   logic               vo_in, vo_ff, ready_o;
   logic [QW-1:0]      qr, qg, qb;
   logic [RB_W-1:0]    red;
   logic [G_W-1:0]     green;
   logic [RB_W-1:0]    blue;
   logic [15:0]        rgb_in, rgb_ff;
   logic               err_ff;

   // order the components by sector and add m
   always_comb begin
      case (info.sector)
         SECT_RED_YEL: begin rv = comp_c; gv = comp_x; bv = '0;     end
         SECT_YEL_GRN: begin rv = comp_x; gv = comp_c; bv = '0;     end
         SECT_GRN_CYN: begin rv = '0;     gv = comp_c; bv = comp_x; end
         SECT_CYN_BLU: begin rv = '0;     gv = comp_x; bv = comp_c; end
         SECT_BLU_MAG: begin rv = comp_x; gv = '0;     bv = comp_c; end
         SECT_MAG_RED: begin rv = comp_c; gv = '0;     bv = comp_x; end
         default:      begin rv = '0;     gv = '0;     bv = '0;     end
      endcase
      ur = rv + comp_m;
      ug = gv + comp_m;
      ub = bv + comp_m;
      // scale by 8 or 16 and drop the ONE^2 fraction; /15 follows
      lr_in = LEVEL_W'(ur >> (2 * FRAC_BITS - 3));
      lg_in = LEVEL_W'(ug >> (2 * FRAC_BITS - 4));
      lb_in = LEVEL_W'(ub >> (2 * FRAC_BITS - 3));
   end

   always_comb begin
      qr     = div15(lr_ff);
      qg     = div15(lg_ff);
      qb     = div15(lb_ff);
      red    = (qr > QW'(RB_MAX)) ? RB_W'(RB_MAX) : RB_W'(qr);
      green  = (qg > QW'(G_MAX))  ? G_W'(G_MAX)   : G_W'(qg);
      blue   = (qb > QW'(RB_MAX)) ? RB_W'(RB_MAX) : RB_W'(qb);
      rgb_in = lvl_err_ff ? '0 : {red, green, blue};
   end

   assign ready_o  = !vo_ff || out_ready;
   assign ready_l  = !vl_ff || ready_o;
   assign in_ready = ready_l;
   assign vl_in    = ready_l ? in_valid : vl_ff;
   assign vo_in    = ready_o ? vl_ff : vo_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vl_ff <= 1'b0;
         vo_ff <= 1'b0;
      end else begin
         vl_ff <= vl_in;
         vo_ff <= vo_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && ready_l) begin
         lr_ff      <= lr_in;
         lg_ff      <= lg_in;
         lb_ff      <= lb_in;
         lvl_err_ff <= info.hue_err;
      end
      if (vl_ff && ready_o) begin
         rgb_ff <= rgb_in;
         err_ff <= lvl_err_ff;
      end
   end

   assign out_valid = vo_ff;
   assign out_rgb   = rgb_ff;
   assign out_err   = err_ff;

`ifndef SYNTHESIS
   a_err_black: assert property (@(posedge clock) disable iff (reset)
      vo_ff && err_ff |-> rgb_ff == '0)
      else $error("hue error response carries a nonzero color");

   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      vl_ff && !lvl_err_ff |-> lr_ff <= LEVEL_W'(RB_LVL_MAX) && lg_ff <= LEVEL_W'(G_LVL_MAX)
                               && lb_ff <= LEVEL_W'(RB_LVL_MAX))
      else $error("scaled level above full scale");

   a_level_moves: assert property (@(posedge clock) disable iff (reset)
      vl_ff && ready_o |=> vo_ff)
      else $error("level stage advanced but output register stayed empty");
`endif

endmodule

/* rtl/hsl_to_rgb565.sv */
// Channel  Dir  Ports                  Contents
// req      in   req_tvalid/tready      tdata: hue_deg [8:0], saturation [17:9],
//                                      lightness [26:18], zero [31:27]
// rsp      out  rsp_tvalid/tready      tdata: rgb565 [15:0]; tuser: hue_error
//
// Five register stages: clamp and sector, chroma multiply, component multiply,
// sector ordering with scaling, divide by 15 with saturation into the output register.
// One request per cycle sustained while rsp_tready stays high.
// Each stage holds its own valid bit and advances when the stage after it is empty or
// draining, so bubbles collapse and a stall on rsp backs up one stage at a time.
// Reset clears the valid bits only; the data registers are not reset.
module hsl_to_rgb565 #(
   parameter int unsigned FRAC_BITS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,     // hue_deg, saturation, lightness, zero pad
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,     // rgb565
   output logic        rsp_tuser      // hue_error
);
   import hsl_pkg::*;

   localparam int unsigned VAL_W  = val_width(FRAC_BITS);
   localparam int unsigned SPAN_W = FRAC_BITS + 1;
   localparam int unsigned U_W    = 2 * FRAC_BITS + 6;

   // request fields
   logic [HUE_W-1:0]  hue_deg, saturation, lightness;

   // sector stage to chroma stages
   logic              sec_valid, sec_ready;
   hue_info_type      sec_info;
   logic [SPAN_W-1:0] sec_span;
   logic [VAL_W-1:0]  sec_sat, sec_light;

   // chroma stages to pack stages
   logic              chr_valid, chr_ready;
   hue_info_type      chr_info;
   logic [U_W-1:0]    chr_c, chr_x, chr_m;

   assign hue_deg    = req_tdata[HUE_W-1:0];
   assign saturation = req_tdata[2*HUE_W-1:HUE_W];
   assign lightness  = req_tdata[3*HUE_W-1:2*HUE_W];

   // clamp inputs, find the hue sector, form 1 - |2L - 1|
   hsl_sector #(.FRAC_BITS(FRAC_BITS)) u_sector (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .hue_deg    (hue_deg),
      .saturation (saturation),
      .lightness  (lightness),
      .out_valid  (sec_valid),
      .out_ready  (sec_ready),
      .info       (sec_info),
      .span       (sec_span),
      .sat        (sec_sat),
      .light      (sec_light)
   );

   // chroma C, second component X and offset m, all exact integers
   hsl_chroma #(.FRAC_BITS(FRAC_BITS)) u_chroma (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sec_valid),
      .in_ready  (sec_ready),
      .in_info   (sec_info),
      .span      (sec_span),
      .sat       (sec_sat),
      .light     (sec_light),
      .out_valid (chr_valid),
      .out_ready (chr_ready),
      .out_info  (chr_info),
      .comp_c    (chr_c),
      .comp_x    (chr_x),
      .comp_m    (chr_m)
   );

   // order components, scale, saturate and pack RGB565
   hsl_pack #(.FRAC_BITS(FRAC_BITS)) u_pack (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (chr_valid),
      .in_ready  (chr_ready),
      .info      (chr_info),
      .comp_c    (chr_c),
      .comp_x    (chr_x),
      .comp_m    (chr_m),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_rgb   (rsp_tdata),
      .out_err   (rsp_tuser)
   );

endmodule

/* tb/hsl_color_checker.sv */
`timescale 1ns / 100ps

module hsl_color_checker #(
   parameter int unsigned FRAC_BITS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [31:0] req_tdata,     // hue_deg [8:0], saturation [17:9], lightness [26:18]
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [15:0] rsp_tdata,     // rgb565
   input  logic        rsp_tuser,     // hue_error
   output int          mismatch_count,
   output int          colors_pending
);
   import hsl_pkg::*;

   localparam int unsigned LEVEL_W = 9;
   localparam longint unsigned UNIT = longint'(1) << FRAC_BITS;
   localparam longint unsigned SPAN = 120 * UNIT * UNIT;

   typedef struct packed {
      logic [15:0] rgb565;
      logic        hue_error;
   } color_type;

   color_type expected_colors[$];

   int mismatches = 0;
   int pending = 0;

   assign mismatch_count = mismatches;
   assign colors_pending = pending;

   // Multiply a component held in 1/(120*UNIT^2) counts, truncate, clip.
   function automatic longint unsigned scale_clip(input longint unsigned counts,
                                                  input longint unsigned mult,
                                                  input longint unsigned top);
      longint unsigned q;
      q = (counts * mult) / SPAN;
      return (q > top) ? top : q;
   endfunction

   function automatic color_type predict_rgb565(input logic [HUE_W-1:0]   hue,
                                                input logic [LEVEL_W-1:0] sat_in,
                                                input logic [LEVEL_W-1:0] light_in);
      longint unsigned sat, light, twice, dev, chroma, offs;
      longint unsigned c120, x120, m120, r_cnt, g_cnt, b_cnt;
      longint unsigned red, green, blue;
      sector_type      sect;
      color_type       res;
      res = '0;
      if (hue >= HUE_LIMIT) begin
         res.hue_error = 1'b1;
         return res;
      end
      sat   = (sat_in > UNIT) ? UNIT : longint'(sat_in);
      light = (light_in > UNIT) ? UNIT : longint'(light_in);
      twice = 2 * light;
      dev   = (twice >= UNIT) ? twice - UNIT : UNIT - twice;
      chroma = (UNIT - dev) * sat;
      sect = sector_type'(hue / SECTOR_DEG);
      offs = hue % SECTOR_DEG;
      // mirror the ramp on odd sectors so X falls instead of rising
      if (sect == SECT_YEL_GRN || sect == SECT_CYN_BLU || sect == SECT_MAG_RED)
         offs = SECTOR_DEG - offs;
      c120 = chroma * 120;
      x120 = chroma * offs * 2;
      m120 = light * UNIT * 120 - chroma * 60;
      case (sect)
         SECT_RED_YEL: begin r_cnt = c120; g_cnt = x120; b_cnt = 0;    end
         SECT_YEL_GRN: begin r_cnt = x120; g_cnt = c120; b_cnt = 0;    end
         SECT_GRN_CYN: begin r_cnt = 0;    g_cnt = c120; b_cnt = x120; end
         SECT_CYN_BLU: begin r_cnt = 0;    g_cnt = x120; b_cnt = c120; end
         SECT_BLU_MAG: begin r_cnt = x120; g_cnt = 0;    b_cnt = c120; end
         default: begin      r_cnt = c120; g_cnt = 0;    b_cnt = x120; end
      endcase
      red   = scale_clip(r_cnt + m120, 32, 31);
      green = scale_clip(g_cnt + m120, 64, 63);
      blue  = scale_clip(b_cnt + m120, 32, 31);
      res.rgb565 = {red[RB_W-1:0], green[G_W-1:0], blue[RB_W-1:0]};
      return res;
   endfunction

   task automatic report_mismatch(input string what);
      $display("[%0t] color mismatch: %s", $time, what);
      mismatches++;
   endtask

   always @(posedge clock) begin
      color_type want;
      if (!reset) begin
         if (req_tvalid && req_tready)
            expected_colors.push_back(predict_rgb565(req_tdata[8:0], req_tdata[17:9],
                                                     req_tdata[26:18]));
         if (rsp_tvalid && rsp_tready) begin
            if (expected_colors.size() == 0) begin
               report_mismatch($sformatf("response %h/%b with no request waiting",
                                         rsp_tdata, rsp_tuser));
            end else begin
               want = expected_colors.pop_front();
               if (rsp_tdata !== want.rgb565)
                  report_mismatch($sformatf("rgb565 %h, want %h", rsp_tdata, want.rgb565));
               if (rsp_tuser !== want.hue_error)
                  report_mismatch($sformatf("hue_error %b, want %b", rsp_tuser,
                                            want.hue_error));
            end
         end
         pending = expected_colors.size();
      end
   end

endmodule

/* tb/tb_hsl_to_rgb565.sv */
`timescale 1ns / 100ps

module tb_hsl_to_rgb565;
   import hsl_pkg::*;

   localparam int unsigned FRAC_BITS = 8;
   localparam int unsigned LEVEL_W = 9;
   localparam int CYCLE_LIMIT = 200000;     // far above the slowest legal run
   localparam int RSP_HOLD_CYCLES = 60;     // long enough to fill all five stages
   localparam int TAIL_CYCLES = 16;         // idle margin after the last response

   logic        clock;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;             // hue_deg [8:0], saturation [17:9],
                                            // lightness [26:18], zero [31:27]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;                  // rgb565
   logic        rsp_tuser;                  // hue_error

   int mismatch_count;
   int colors_pending;
   int cycle_count = 0;

   // Flow-control knobs shared between the request and response processes
   bit req_gaps_on = 1'b1;
   bit rsp_gaps_on = 1'b1;
   bit stall_rsp = 1'b0;

   hsl_to_rgb565 #(
      .FRAC_BITS (FRAC_BITS)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   hsl_color_checker #(
      .FRAC_BITS (FRAC_BITS)
   ) u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .mismatch_count (mismatch_count),
      .colors_pending (colors_pending)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Hold reset from time zero, then release it on a falling edge for good.
   initial begin
      repeat (7) @(negedge clock);
      reset <= 1'b0;
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   // Abort a hung run.
   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("hsl_to_rgb565 verification failed");
      $finish;
   end

   // Mostly short idle stretches, now and then a long one.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Saturation or lightness: mostly in range, some above one to hit the clamp.
   function automatic logic [LEVEL_W-1:0] pick_level();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 80) return LEVEL_W'($urandom_range(0, 256));
      if (roll < 90) return LEVEL_W'($urandom_range(257, 511));
      return LEVEL_W'($urandom_range(0, 511));
   endfunction

   // Response side: toggle tready in random runs, and obey a stall request by
   // holding tready low for the RSP_HOLD_CYCLES hold.
   initial begin
      int hold_left;
      int run_left;
      int idle_left;
      hold_left = 0;
      run_left = 0;
      idle_left = 0;
      forever begin
         @(negedge clock);
         if (stall_rsp) begin
            hold_left = RSP_HOLD_CYCLES;
            stall_rsp = 1'b0;
         end
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else if (run_left > 0) begin
            rsp_tready <= 1'b1;
            run_left--;
         end else if (idle_left > 0) begin
            rsp_tready <= 1'b0;
            idle_left--;
         end else begin
            run_left = $urandom_range(1, 12);
            idle_left = rsp_gaps_on ? pick_gap() : 0;
            rsp_tready <= 1'b1;
         end
      end
   end

   // Offer one request after an optional gap and hold it until accepted.
   // Enter and leave on a falling edge.
   task automatic send_request(input logic [HUE_W-1:0]   hue,
                               input logic [LEVEL_W-1:0] sat,
                               input logic [LEVEL_W-1:0] light);
      int gap;
      gap = req_gaps_on ? pick_gap() : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tdata  <= {5'b0, light, sat, hue};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // Mostly valid hues, the rest in the out-of-range band.
   task automatic send_random();
      logic [HUE_W-1:0] hue;
      hue = ($urandom_range(0, 99) < 88) ? HUE_W'($urandom_range(0, HUE_LIMIT - 1))
                                         : HUE_W'($urandom_range(HUE_LIMIT, 511));
      send_request(hue, pick_level(), pick_level());
   endtask

   task automatic wait_drained();
      while (colors_pending != 0) @(negedge clock);
   endtask

   initial begin
      while (reset) @(negedge clock);

      // Directed: every sector start and the ends of sectors 0, 1 and 5 at full
      // saturation, the out-of-range hue band, and clamped saturation and lightness.
      send_request(0,   256, 128);
      send_request(59,  256, 128);
      send_request(60,  256, 128);
      send_request(119, 256, 128);
      send_request(120, 256, 128);
      send_request(180, 256, 128);
      send_request(240, 256, 128);
      send_request(300, 256, 128);
      send_request(359, 256, 128);
      send_request(1,   256, 128);
      // black, white and full-lightness cases where a component reaches 1.0
      send_request(0,   0,   0);
      send_request(0,   0,   256);
      send_request(0,   256, 256);
      send_request(0,   256, 0);
      // saturation and lightness above one clamp to one
      send_request(200, 511, 511);
      send_request(30,  257, 100);
      send_request(90,  100, 300);
      // hue out of range gives a zero color and the error flag
      send_request(360, 256, 128);
      send_request(511, 511, 511);
      send_request(360, 0,   0);
      // scattered mid values across the sectors
      send_request(150, 256, 1);
      send_request(210, 255, 255);
      send_request(270, 128, 64);
      send_request(330, 1,   200);

      // Random traffic with idling on both sides
      repeat (200) send_random();

      // Let the pipe empty completely before the stall test.
      req_tvalid <= 1'b0;
      wait_drained();

      // Stall the response side and keep pushing requests back to back so
      // the stages fill and req_tready drops.
      req_gaps_on = 1'b0;
      stall_rsp = 1'b1;
      repeat (40) send_random();

      // Full rate: no idling on either side.
      rsp_gaps_on = 1'b0;
      repeat (100) send_random();

      // Back to random idling for the rest.
      req_gaps_on = 1'b1;
      rsp_gaps_on = 1'b1;
      repeat (190) send_random();

      req_tvalid <= 1'b0;
      wait_drained();
      repeat (TAIL_CYCLES) @(negedge clock);

      if (mismatch_count == 0)
         $display("hsl_to_rgb565 verification clean");
      else
         $display("hsl_to_rgb565 verification failed");
      $finish;
   end

endmodule

/* sim.f */
rtl/hsl_pkg.sv
rtl/hsl_sector.sv
rtl/hsl_chroma.sv
rtl/hsl_pack.sv
rtl/hsl_to_rgb565.sv
tb/hsl_color_checker.sv
tb/tb_hsl_to_rgb565.sv
